// ===== src/jnp_pkg.sv =====
// ---------------------------------------------------------------------------
// jnp_pkg
// Types and constants shared by the nine-point Jacobi solver modules.
// ---------------------------------------------------------------------------
package jnp_pkg;

   localparam int TAPS       = 9;
   localparam int TAP_W      = 4;
   localparam int TAP_CENTRE = 4;
   localparam int TAP_LAST   = 8;
   localparam int GRID_W     = 6;
   localparam int TOL_W      = 40;
   localparam int CAP_W      = 16;
   localparam int SWEEP_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   localparam logic [GRID_W-1:0] COLS_RESET = 6'd32;
   localparam logic [GRID_W-1:0] ROWS_RESET = 6'd32;
   localparam logic [TOL_W-1:0]  TOL_RESET  = 40'd1048576;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd1000;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_SOLVE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_CAP  = 2'd1,
      ST_ZERO = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1,
      CSR_TOL_SQ    = 2'd2,
      CSR_ITER_CAP  = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_CHK_RD, S_CHK_TST, S_COPY_RD, S_COPY_WR, S_PT_RD, S_PT_INIT,
      S_TAP, S_TAP_MUL, S_TAP_ACC, S_DIV_START, S_DIV, S_FIN, S_DIFF, S_SQ,
      S_SUM, S_SWEEP_END
   } state_type;

   typedef struct packed {
      logic             load_we;
      logic             prev_we;
      logic             sol_we;
      logic             prev_nbr;
      logic             num_init;
      logic             mul_en;
      logic             num_acc;
      logic             div_start;
      logic             div_step;
      logic             fin;
      logic             diff_en;
      logic             sq_en;
      logic             sum_acc;
      logic             sum_clr;
      logic [TAP_W-1:0] tap;
   } dp_cmd_type;

   typedef struct packed {
      logic centre_zero;
      logic converged;
   } dp_stat_type;

   // Neighbour direction of each tap, in the order sw, w, nw, s, c, n, se, e, ne.
   function automatic logic tap_west(logic [TAP_W-1:0] k);
      return k < 4'd3;
   endfunction

   function automatic logic tap_east(logic [TAP_W-1:0] k);
      return (k >= 4'd6) && (k <= 4'd8);
   endfunction

   function automatic logic tap_south(logic [TAP_W-1:0] k);
      return (k == 4'd0) || (k == 4'd3) || (k == 4'd6);
   endfunction

   function automatic logic tap_north(logic [TAP_W-1:0] k);
      return (k == 4'd2) || (k == 4'd5) || (k == 4'd8);
   endfunction

endpackage

// ===== src/jnp_dp.sv =====
// ---------------------------------------------------------------------------
// jnp_dp
// Solver datapath: point stores, multiply-accumulate, serial divider and
// squared-change accumulator.
// ---------------------------------------------------------------------------
module jnp_dp #(
   parameter int MAX_COLS   = 32,
   parameter int MAX_ROWS   = 32,
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 20
) (
   input  logic                                             clock,
   input  jnp_pkg::dp_cmd_type                              cmd,
   input  logic [((MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] paddr,
   input  logic [((MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] naddr,
   input  logic [jnp_pkg::TAPS-1:0][DATA_WIDTH-1:0]         coef_in,
   input  logic [DATA_WIDTH-1:0]                            rhs_in,
   input  logic [DATA_WIDTH-1:0]                            guess_in,
   input  logic [jnp_pkg::TOL_W-1:0]                        tol_in,
   output jnp_pkg::dp_stat_type                             stat,
   output logic [DATA_WIDTH-1:0]                            sol_rdata
);
   import jnp_pkg::*;

   localparam int POINTS = MAX_COLS * MAX_ROWS;
   localparam int AW     = POINTS > 1 ? $clog2(POINTS) : 1;
   localparam int D      = DATA_WIDTH;
   localparam int NW     = 2 * DATA_WIDTH + 5;
   localparam int SW     = 2 * DATA_WIDTH + AW + 10;

   logic [TAPS-1:0][D-1:0] coef_rd;
   logic [D-1:0]           rhs_mem [POINTS];
   logic [D-1:0]           sol_mem [POINTS];
   logic [D-1:0]           prev_mem [POINTS];
   logic [D-1:0]           rhs_rd_ff;
   logic [D-1:0]           sol_rd_ff;
   logic [D-1:0]           prev_rd_ff;
   logic [AW-1:0]          prev_raddr;

   logic signed [D-1:0]    centre_ff;
   logic signed [NW-1:0]   num_ff;
   logic signed [2*D-1:0]  prod_ff;
   logic signed [D-1:0]    mul_a;
   logic signed [D-1:0]    mul_b;
   logic [NW-1:0]          quo_ff;
   logic [D-1:0]           rem_ff;
   logic [D-1:0]           dvs_ff;
   logic                   neg_ff;
   logic [D:0]             trial;
   logic [NW-1:0]          limit;
   logic [NW-1:0]          sat;
   logic [D-1:0]           new_ff;
   logic signed [D:0]      d_ff;
   logic [D:0]             d_mag;
   logic [2*D+1:0]         sq_ff;
   logic [SW-1:0]          sum_ff;

   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      logic [D-1:0] cmem [POINTS];
      logic [D-1:0] crd_ff;
      always_ff @(posedge clock) begin
         if (cmd.load_we) begin
            cmem[paddr] <= coef_in[t];
         end
         crd_ff <= cmem[paddr];
      end
      assign coef_rd[t] = crd_ff;
   end

   assign prev_raddr = cmd.prev_nbr ? naddr : paddr;

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         rhs_mem[paddr] <= rhs_in;
      end
      rhs_rd_ff <= rhs_mem[paddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         sol_mem[paddr] <= guess_in;
      end else if (cmd.sol_we) begin
         sol_mem[paddr] <= new_ff;
      end
      sol_rd_ff <= sol_mem[paddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.prev_we) begin
         prev_mem[paddr] <= sol_rd_ff;
      end
      prev_rd_ff <= prev_mem[prev_raddr];
   end

   assign mul_a = coef_rd[cmd.tap];
   assign mul_b = prev_rd_ff;
   assign trial = {rem_ff, quo_ff[NW-1]};
   assign limit = neg_ff ? (NW'(1) << (D - 1)) : ((NW'(1) << (D - 1)) - NW'(1));
   assign sat   = (quo_ff > limit) ? limit : quo_ff;
   assign d_mag = d_ff[D] ? (D+1)'(-d_ff) : (D+1)'(d_ff);

   always_ff @(posedge clock) begin
      if (cmd.num_init) begin
         centre_ff <= coef_rd[TAP_CENTRE];
         num_ff    <= $signed({{(NW-D){rhs_rd_ff[D-1]}}, rhs_rd_ff}) <<< FRAC_BITS;
      end else if (cmd.num_acc) begin
         num_ff <= num_ff - $signed({{(NW-2*D){prod_ff[2*D-1]}}, prod_ff});
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.div_start) begin
         neg_ff <= num_ff[NW-1] ^ centre_ff[D-1];
         quo_ff <= num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
         dvs_ff <= centre_ff[D-1] ? D'(-centre_ff) : D'(centre_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_ff <= D'(trial - {1'b0, dvs_ff});
            quo_ff <= {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_ff <= D'(trial);
            quo_ff <= {quo_ff[NW-2:0], 1'b0};
         end
      end
      if (cmd.fin) begin
         new_ff <= neg_ff ? D'(-sat) : D'(sat);
      end
      if (cmd.diff_en) begin
         d_ff <= $signed({new_ff[D-1], new_ff}) - $signed({prev_rd_ff[D-1], prev_rd_ff});
      end
      if (cmd.sq_en) begin
         sq_ff <= d_mag * d_mag;
      end
      if (cmd.sum_clr) begin
         sum_ff <= '0;
      end else if (cmd.sum_acc) begin
         sum_ff <= sum_ff + SW'(sq_ff);
      end
   end

   assign stat.centre_zero = (coef_rd[TAP_CENTRE] == '0);
   assign stat.converged   = (sum_ff <= SW'(tol_in));
   assign sol_rdata        = sol_rd_ff;

endmodule

// ===== src/jnp_ctrl.sv =====
// ---------------------------------------------------------------------------
// jnp_ctrl
// Solver controller: configuration registers, command decode, grid walk and
// sweep sequencing.
// ---------------------------------------------------------------------------
module jnp_ctrl #(
   parameter int MAX_COLS   = 32,
   parameter int MAX_ROWS   = 32,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             start,
   output logic                                             busy,
   input  logic [1:0]                                       req_command,
   input  logic                                             csr_we,
   input  logic [jnp_pkg::CSR_IDX_W-1:0]                    csr_index,
   input  logic [jnp_pkg::CSR_DATA_W-1:0]                   csr_wdata,
   output jnp_pkg::dp_cmd_type                              cmd,
   input  jnp_pkg::dp_stat_type                             stat,
   output logic [((MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] paddr,
   output logic [((MAX_COLS*MAX_ROWS) > 1 ? $clog2(MAX_COLS*MAX_ROWS) : 1)-1:0] naddr,
   output logic [jnp_pkg::TOL_W-1:0]                        tol,
   output logic                                             rsp_valid,
   output logic                                             rsp_is_read,
   output logic [1:0]                                       rsp_status,
   output logic [jnp_pkg::SWEEP_W-1:0]                      rsp_sweeps_done,
   output logic                                             rsp_last_point
);
   import jnp_pkg::*;

   localparam int POINTS = MAX_COLS * MAX_ROWS;
   localparam int AW     = POINTS > 1 ? $clog2(POINTS) : 1;
   localparam int PW     = $clog2(POINTS + 1);
   localparam int CW     = $clog2(MAX_COLS + 1);
   localparam int RW     = $clog2(MAX_ROWS + 1);
   localparam int NW     = 2 * DATA_WIDTH + 5;
   localparam int DCW    = $clog2(NW);

   logic [GRID_W-1:0]  cols_ff, rows_ff;
   logic [TOL_W-1:0]   tol_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [CW-1:0]      cols_eff;
   logic [RW-1:0]      rows_eff;
   logic [CAP_W-1:0]   cap_eff;
   logic [PW-1:0]      n_pts;

   state_type          state_ff, state_in;
   logic [PW-1:0]      p_ff, p_in;
   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [TAP_W-1:0]   k_ff, k_in;
   logic [DCW-1:0]     dcnt_ff, dcnt_in;
   logic [PW-1:0]      load_idx_ff, load_idx_in;
   logic [PW-1:0]      read_idx_ff, read_idx_in;
   logic [SWEEP_W-1:0] sweeps_ff, sweeps_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_read_ff, rsp_read_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [PW-1:0]      load_cur, load_nxt, read_cur, read_nxt;
   logic [PW+1:0]      nbr;
   logic               in_grid;
   logic               last_p, last_col;

   always_comb begin
      if (cols_ff == '0) begin
         cols_eff = CW'(1);
      end else if (32'(cols_ff) > MAX_COLS) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(cols_ff);
      end
      if (rows_ff == '0) begin
         rows_eff = RW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(rows_ff);
      end
   end

   assign n_pts    = PW'(32'(cols_eff) * 32'(rows_eff));
   assign cap_eff  = (cap_ff == '0) ? CAP_W'(1) : cap_ff;
   assign load_cur = (load_idx_ff < n_pts) ? load_idx_ff : '0;
   assign load_nxt = (PW'(load_cur + 1'b1) >= n_pts) ? '0 : PW'(load_cur + 1'b1);
   assign read_cur = (read_idx_ff < n_pts) ? read_idx_ff : '0;
   assign read_nxt = (PW'(read_cur + 1'b1) >= n_pts) ? '0 : PW'(read_cur + 1'b1);
   assign last_p   = (p_ff == PW'(n_pts - 1'b1));
   assign last_col = (col_ff == CW'(cols_eff - 1'b1));

   always_comb begin
      nbr = (PW+2)'(p_ff);
      if (tap_north(k_ff)) begin
         nbr = nbr + (PW+2)'(cols_eff);
      end else if (tap_south(k_ff)) begin
         nbr = nbr - (PW+2)'(cols_eff);
      end
      if (tap_east(k_ff)) begin
         nbr = nbr + 1'b1;
      end else if (tap_west(k_ff)) begin
         nbr = nbr - 1'b1;
      end
   end

   assign naddr   = AW'(nbr);
   assign in_grid = !(tap_west(k_ff) && col_ff == '0) && !(tap_east(k_ff) && last_col)
                    && !(tap_south(k_ff) && row_ff == '0)
                    && !(tap_north(k_ff) && row_ff == RW'(rows_eff - 1'b1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         tol_ff  <= TOL_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_COLS: cols_ff <= csr_wdata[GRID_W-1:0];
            CSR_GRID_ROWS: rows_ff <= csr_wdata[GRID_W-1:0];
            CSR_TOL_SQ:    tol_ff  <= csr_wdata[TOL_W-1:0];
            CSR_ITER_CAP:  cap_ff  <= csr_wdata[CAP_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_ff         <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         k_ff         <= '0;
         dcnt_ff      <= '0;
         load_idx_ff  <= '0;
         read_idx_ff  <= '0;
         sweeps_ff    <= '0;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         dcnt_ff      <= dcnt_in;
         load_idx_ff  <= load_idx_in;
         read_idx_ff  <= read_idx_in;
         sweeps_ff    <= sweeps_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_read_ff  <= rsp_read_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      dcnt_in      = dcnt_ff;
      load_idx_in  = load_idx_ff;
      read_idx_in  = read_idx_ff;
      sweeps_in    = sweeps_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_read_in  = rsp_read_ff;
      rsp_last_in  = rsp_last_ff;
      cmd          = '0;
      cmd.tap      = k_ff;
      paddr        = AW'(p_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (command_type'(req_command))
                  CMD_LOAD: begin
                     cmd.load_we = 1'b1;
                     paddr       = AW'(load_cur);
                     load_idx_in = load_nxt;
                  end
                  CMD_SOLVE: begin
                     read_idx_in = '0;
                     sweeps_in   = '0;
                     p_in        = '0;
                     state_in    = S_CHK_RD;
                  end
                  CMD_READ: begin
                     paddr        = AW'(read_cur);
                     rsp_valid_in = 1'b1;
                     rsp_read_in  = 1'b1;
                     rsp_last_in  = (PW'(read_cur + 1'b1) >= n_pts);
                     read_idx_in  = read_nxt;
                  end
                  CMD_NONE: begin
                  end
               endcase
            end
         end
         S_CHK_RD: state_in = S_CHK_TST;
         S_CHK_TST: begin
            if (stat.centre_zero) begin
               status_in    = ST_ZERO;
               rsp_valid_in = 1'b1;
               rsp_read_in  = 1'b0;
               rsp_last_in  = 1'b0;
               state_in     = S_IDLE;
            end else if (last_p) begin
               p_in     = '0;
               state_in = S_COPY_RD;
            end else begin
               p_in     = PW'(p_ff + 1'b1);
               state_in = S_CHK_RD;
            end
         end
         S_COPY_RD: begin
            cmd.sum_clr = 1'b1;
            state_in    = S_COPY_WR;
         end
         S_COPY_WR: begin
            cmd.prev_we = 1'b1;
            if (last_p) begin
               p_in     = '0;
               col_in   = '0;
               row_in   = '0;
               state_in = S_PT_RD;
            end else begin
               p_in     = PW'(p_ff + 1'b1);
               state_in = S_COPY_RD;
            end
         end
         S_PT_RD: state_in = S_PT_INIT;
         S_PT_INIT: begin
            cmd.num_init = 1'b1;
            k_in         = '0;
            state_in     = S_TAP;
         end
         S_TAP: begin
            if (k_ff == TAP_W'(TAP_CENTRE) || !in_grid) begin
               if (k_ff == TAP_W'(TAP_LAST)) begin
                  state_in = S_DIV_START;
               end else begin
                  k_in = TAP_W'(k_ff + 1'b1);
               end
            end else begin
               cmd.prev_nbr = 1'b1;
               state_in     = S_TAP_MUL;
            end
         end
         S_TAP_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_TAP_ACC;
         end
         S_TAP_ACC: begin
            cmd.num_acc = 1'b1;
            if (k_ff == TAP_W'(TAP_LAST)) begin
               state_in = S_DIV_START;
            end else begin
               k_in     = TAP_W'(k_ff + 1'b1);
               state_in = S_TAP;
            end
         end
         S_DIV_START: begin
            cmd.div_start = 1'b1;
            dcnt_in       = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (dcnt_ff == DCW'(NW - 1)) begin
               state_in = S_FIN;
            end else begin
               dcnt_in = DCW'(dcnt_ff + 1'b1);
            end
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.diff_en = 1'b1;
            cmd.sol_we  = 1'b1;
            state_in    = S_SQ;
         end
         S_SQ: begin
            cmd.sq_en = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.sum_acc = 1'b1;
            if (last_p) begin
               state_in = S_SWEEP_END;
            end else begin
               p_in = PW'(p_ff + 1'b1);
               if (last_col) begin
                  col_in = '0;
                  row_in = RW'(row_ff + 1'b1);
               end else begin
                  col_in = CW'(col_ff + 1'b1);
               end
               state_in = S_PT_RD;
            end
         end
         S_SWEEP_END: begin
            sweeps_in = SWEEP_W'(sweeps_ff + 1'b1);
            if (stat.converged || SWEEP_W'(sweeps_ff + 1'b1) >= cap_eff) begin
               status_in    = stat.converged ? ST_OK : ST_CAP;
               rsp_valid_in = 1'b1;
               rsp_read_in  = 1'b0;
               rsp_last_in  = 1'b0;
               state_in     = S_IDLE;
            end else begin
               p_in     = '0;
               state_in = S_COPY_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy            = (state_ff != S_IDLE);
   assign tol             = tol_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_read     = rsp_read_ff;
   assign rsp_status      = status_ff;
   assign rsp_sweeps_done = sweeps_ff;
   assign rsp_last_point  = rsp_last_ff;

endmodule

// ===== src/jacobi_nine_point_solver_top.sv =====
// ---------------------------------------------------------------------------
// jacobi_nine_point_solver_top
// Nine-point Jacobi solver over a grid of up to MAX_ROWS by MAX_COLS points.
//
// An item is taken when start is high and busy is low. A load item writes
// the next point's nine coefficients, right-hand side and starting value and
// gives no result; loads stream at one item per cycle. A read item returns
// the next solution point in the next cycle on the rsp_ ports, marked by
// rsp_valid for one cycle; reads also stream at one item per cycle.
// A solve item holds busy high until its result appears: a centre check of
// every point, then per sweep a copy of every point into the previous-value
// store and, per point, the in-grid neighbour taps and a bit-serial divider
// of width NW = 2*DATA_WIDTH+5, and one more step to close the sweep. The
// receiver cannot stall, so each result is shown for exactly one cycle.
// Reset clears control state and sets the configuration registers to their
// defaults; the point stores hold nothing valid until loaded.
// ---------------------------------------------------------------------------
module jacobi_nine_point_solver_top #(
   parameter int MAX_COLS   = 32,
   parameter int MAX_ROWS   = 32,
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_command,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_sw,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_w,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_nw,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_s,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_center,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_n,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_se,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_e,
   input  logic signed [DATA_WIDTH-1:0]          req_coef_ne,
   input  logic signed [DATA_WIDTH-1:0]          req_rhs_value,
   input  logic signed [DATA_WIDTH-1:0]          req_initial_guess,
   output logic                                  rsp_valid,
   output logic signed [DATA_WIDTH-1:0]          rsp_solution_value,
   output logic [1:0]                            rsp_status,
   output logic [jnp_pkg::SWEEP_W-1:0]           rsp_sweeps_done,
   output logic                                  rsp_last_point,
   input  logic                                  csr_we,
   input  logic [jnp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jnp_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import jnp_pkg::*;

   localparam int POINTS = MAX_COLS * MAX_ROWS;
   localparam int AW     = POINTS > 1 ? $clog2(POINTS) : 1;

   dp_cmd_type                       cmd;
   dp_stat_type                      stat;
   logic [AW-1:0]                    paddr;
   logic [AW-1:0]                    naddr;
   logic [TOL_W-1:0]                 tol;
   logic [TAPS-1:0][DATA_WIDTH-1:0]  coef_bus;
   logic [DATA_WIDTH-1:0]            sol_rdata;
   logic                             rsp_is_read;

   assign coef_bus[0] = req_coef_sw;
   assign coef_bus[1] = req_coef_w;
   assign coef_bus[2] = req_coef_nw;
   assign coef_bus[3] = req_coef_s;
   assign coef_bus[4] = req_coef_center;
   assign coef_bus[5] = req_coef_n;
   assign coef_bus[6] = req_coef_se;
   assign coef_bus[7] = req_coef_e;
   assign coef_bus[8] = req_coef_ne;

   jnp_ctrl #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .paddr           (paddr),
      .naddr           (naddr),
      .tol             (tol),
      .rsp_valid       (rsp_valid),
      .rsp_is_read     (rsp_is_read),
      .rsp_status      (rsp_status),
      .rsp_sweeps_done (rsp_sweeps_done),
      .rsp_last_point  (rsp_last_point)
   );

   jnp_dp #(
      .MAX_COLS   (MAX_COLS),
      .MAX_ROWS   (MAX_ROWS),
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .paddr     (paddr),
      .naddr     (naddr),
      .coef_in   (coef_bus),
      .rhs_in    (req_rhs_value),
      .guess_in  (req_initial_guess),
      .tol_in    (tol),
      .stat      (stat),
      .sol_rdata (sol_rdata)
   );

   assign rsp_solution_value = rsp_is_read ? sol_rdata : '0;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the nine-point Jacobi solver.
//
// An initial block fills a queue with register writes and items, grouped in
// phases: each phase sets the grid and stopping rule, loads every point in
// use, then mixes solves, reads, loads and ignored items. A clocked driver
// presents the items with random gaps and a clocked monitor checks every
// result against a predictor that keeps its own copy of the point stores.
// ---------------------------------------------------------------------------
module tb_top;
   import jnp_pkg::*;

   localparam int DW        = 32;
   localparam int FB        = 20;
   localparam int GRID_MAX  = 32;
   localparam int SETTLE    = 12;
   localparam int STALL_MAX = 200000;
   localparam logic [TOL_W-1:0] TOL_MAX = '1;

   typedef enum int {
      MIX_RAW,
      MIX_DOMINANT,
      MIX_DIAGONAL,
      MIX_ZERO_CENTRE
   } mix_type;

   typedef struct packed {
      logic                   is_csr;
      csr_index_type          reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      command_type            command;
      logic [8:0][DW-1:0]     coef;
      logic [DW-1:0]          rhs;
      logic [DW-1:0]          guess;
   } stim_type;

   typedef struct packed {
      logic [DW-1:0]       value;
      logic [1:0]          status;
      logic [SWEEP_W-1:0]  sweeps;
      logic                last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = '0;
   logic signed [DW-1:0] req_coef_sw = '0, req_coef_w = '0, req_coef_nw = '0;
   logic signed [DW-1:0] req_coef_s = '0, req_coef_center = '0, req_coef_n = '0;
   logic signed [DW-1:0] req_coef_se = '0, req_coef_e = '0, req_coef_ne = '0;
   logic signed [DW-1:0] req_rhs_value = '0, req_initial_guess = '0;
   logic rsp_valid;
   logic signed [DW-1:0] rsp_solution_value;
   logic [1:0] rsp_status;
   logic [SWEEP_W-1:0] rsp_sweeps_done;
   logic rsp_last_point;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   stim_type   pending_q[$];
   answer_type answer_q[$];
   stim_type   on_port;
   stim_type   next_stim;
   int         errors = 0;
   int         quiet = 0;
   int         stall = 0;
   int         items_sent = 0;
   int         items_built = 0;

   // Predictor state.
   logic signed [DW-1:0] coef_mem [GRID_MAX*GRID_MAX][9];
   logic signed [DW-1:0] rhs_mem  [GRID_MAX*GRID_MAX];
   logic signed [DW-1:0] sol_mem  [GRID_MAX*GRID_MAX];
   logic signed [DW-1:0] old_mem  [GRID_MAX*GRID_MAX];
   int                   load_at = 0;
   int                   read_at = 0;
   logic [SWEEP_W-1:0]   sweeps_held = '0;
   logic [1:0]           status_held = ST_OK;
   logic [GRID_W-1:0]    cols_reg = COLS_RESET;
   logic [GRID_W-1:0]    rows_reg = ROWS_RESET;
   logic [TOL_W-1:0]     tol_reg = TOL_RESET;
   logic [CAP_W-1:0]     cap_reg = CAP_RESET;

   jacobi_nine_point_solver_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int grid_extent(logic [GRID_W-1:0] v);
      if (v == 0) return 1;
      return (v > GRID_MAX) ? GRID_MAX : int'(v);
   endfunction

   function automatic logic signed [DW-1:0] sweep_point(int p, int rows, int cols);
      logic signed [127:0] num, a, b, q;
      int r, c, nc, nr;
      r = p / cols;
      c = p % cols;
      num = rhs_mem[p];
      num = num <<< FB;
      for (int k = 0; k < 9; k++) begin
         nc = c + k / 3 - 1;
         nr = r + k % 3 - 1;
         if (k != TAP_CENTRE && nc >= 0 && nr >= 0 && nc < cols && nr < rows) begin
            a = coef_mem[p][k];
            b = old_mem[nr * cols + nc];
            num = num - a * b;
         end
      end
      a = coef_mem[p][TAP_CENTRE];
      q = num / a;
      if (q > 128'sd2147483647) return 32'sh7fffffff;
      if (q < -128'sd2147483648) return 32'sh80000000;
      return q[DW-1:0];
   endfunction

   task automatic run_solve();
      int cols, rows, n, cap;
      logic [127:0] total, d;
      logic signed [63:0] diff;
      bit done;
      cols = grid_extent(cols_reg);
      rows = grid_extent(rows_reg);
      n = cols * rows;
      cap = (cap_reg == 0) ? 1 : int'(cap_reg);
      sweeps_held = '0;
      for (int p = 0; p < n; p++) begin
         if (coef_mem[p][TAP_CENTRE] == 0) begin
            status_held = ST_ZERO;
            return;
         end
      end
      do begin
         total = '0;
         for (int p = 0; p < n; p++) old_mem[p] = sol_mem[p];
         for (int p = 0; p < n; p++) begin
            sol_mem[p] = sweep_point(p, rows, cols);
            diff = 64'(sol_mem[p]) - 64'(old_mem[p]);
            d = (diff < 0) ? 128'(-diff) : 128'(diff);
            total = total + d * d;
         end
         sweeps_held++;
         done = total <= 128'(tol_reg);
      end while (!done && sweeps_held < cap);
      status_held = done ? ST_OK : ST_CAP;
   endtask

   task automatic predict_item(stim_type s);
      int n, idx;
      answer_type ans;
      n = grid_extent(cols_reg) * grid_extent(rows_reg);
      case (s.command)
         CMD_LOAD: begin
            idx = (load_at < n) ? load_at : 0;
            for (int k = 0; k < 9; k++) coef_mem[idx][k] = s.coef[k];
            rhs_mem[idx] = s.rhs;
            sol_mem[idx] = s.guess;
            load_at = (idx + 1 >= n) ? 0 : idx + 1;
         end
         CMD_SOLVE: begin
            run_solve();
            read_at = 0;
            ans = '{value: '0, status: status_held, sweeps: sweeps_held, last: 1'b0};
            answer_q.push_back(ans);
         end
         CMD_READ: begin
            idx = (read_at < n) ? read_at : 0;
            ans = '{value: sol_mem[idx], status: status_held, sweeps: sweeps_held,
                    last: (idx + 1 >= n)};
            read_at = (idx + 1 >= n) ? 0 : idx + 1;
            answer_q.push_back(ans);
         end
         default: ;
      endcase
   endtask

   function automatic logic [DW-1:0] raw_word();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [DW-1:0] small_word();
      logic [DW-1:0] v;
      v = $urandom_range(0, 1 << 17);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic stim_type make_item(command_type cmd, mix_type mix);
      stim_type s;
      s = '0;
      s.command = cmd;
      for (int k = 0; k < 9; k++) s.coef[k] = raw_word();
      s.rhs = raw_word();
      s.guess = raw_word();
      if (cmd == CMD_LOAD && mix != MIX_RAW) begin
         for (int k = 0; k < 9; k++)
            s.coef[k] = (mix == MIX_DIAGONAL) ? '0 : small_word();
         s.coef[TAP_CENTRE] = $urandom_range(1 << 20, 1 << 22);
         if ($urandom_range(0, 1)) s.coef[TAP_CENTRE] = -s.coef[TAP_CENTRE];
         if (mix == MIX_ZERO_CENTRE && $urandom_range(0, 3) == 0) s.coef[TAP_CENTRE] = '0;
      end else if (cmd == CMD_LOAD && s.coef[TAP_CENTRE] == 0 && $urandom_range(0, 7) != 0) begin
         s.coef[TAP_CENTRE] = 32'h00100000;
      end
      return s;
   endfunction

   task automatic add_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
      stim_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.reg_index = idx;
      s.reg_value = v;
      pending_q.push_back(s);
   endtask

   task automatic add_item(command_type cmd, mix_type mix);
      pending_q.push_back(make_item(cmd, mix));
      items_built++;
   endtask

   task automatic add_phase(int cols_w, int rows_w, logic [TOL_W-1:0] tol,
                            logic [CAP_W-1:0] cap, mix_type mix, int extra);
      int n;
      add_csr(CSR_GRID_COLS, cols_w);
      add_csr(CSR_GRID_ROWS, rows_w);
      add_csr(CSR_TOL_SQ, tol);
      add_csr(CSR_ITER_CAP, cap);
      n = grid_extent(cols_w) * grid_extent(rows_w);
      for (int i = 0; i < n; i++) add_item(CMD_LOAD, mix);
      add_item(CMD_SOLVE, mix);
      for (int i = 0; i <= n; i++) add_item(CMD_READ, mix);
      for (int i = 0; i < extra; i++) begin
         case ($urandom_range(0, 99)) inside
            [0:64]:  add_item(CMD_LOAD, mix);
            [65:89]: add_item(CMD_READ, mix);
            [90:93]: add_item(CMD_SOLVE, mix);
            default: add_item(CMD_NONE, mix);
         endcase
      end
   endtask

   function automatic logic [TOL_W-1:0] pick_tolerance();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return TOL_MAX;
         2: return {8'($urandom), 32'($urandom)};
         default: return 40'($urandom_range(0, 1 << 24));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         quiet <= 0;
      end else begin
         if (start && !busy) predict_item(on_port);
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_COLS: cols_reg = csr_wdata[GRID_W-1:0];
               CSR_GRID_ROWS: rows_reg = csr_wdata[GRID_W-1:0];
               CSR_TOL_SQ:    tol_reg = csr_wdata[TOL_W-1:0];
               default:       cap_reg = csr_wdata[CAP_W-1:0];
            endcase
         end
         quiet <= (start || busy || csr_we || answer_q.size() != 0) ? 0 : quiet + 1;
         if (!(start && busy)) begin
            next_stim = '0;
            if (pending_q.size() != 0 && pending_q[0].is_csr) begin
               if (!start && !csr_we && quiet >= SETTLE && answer_q.size() == 0) begin
                  next_stim = pending_q.pop_front();
                  csr_index <= next_stim.reg_index;
                  csr_wdata <= next_stim.reg_value;
                  csr_we <= 1'b1;
               end else begin
                  csr_we <= 1'b0;
               end
               start <= 1'b0;
            end else begin
               csr_we <= 1'b0;
               if (pending_q.size() != 0 &&
                   ((items_sent > 500 && items_sent < 700) || $urandom_range(0, 99) >= 10)) begin
                  next_stim = pending_q.pop_front();
                  on_port <= next_stim;
                  items_sent <= items_sent + 1;
                  start <= 1'b1;
                  req_command <= next_stim.command;
                  req_coef_sw <= next_stim.coef[0];
                  req_coef_w <= next_stim.coef[1];
                  req_coef_nw <= next_stim.coef[2];
                  req_coef_s <= next_stim.coef[3];
                  req_coef_center <= next_stim.coef[4];
                  req_coef_n <= next_stim.coef[5];
                  req_coef_se <= next_stim.coef[6];
                  req_coef_e <= next_stim.coef[7];
                  req_coef_ne <= next_stim.coef[8];
                  req_rhs_value <= next_stim.rhs;
                  req_initial_guess <= next_stim.guess;
               end else begin
                  start <= 1'b0;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            $error("result with nothing expected: value %h", rsp_solution_value);
            errors++;
         end else begin
            want = answer_q.pop_front();
            if (rsp_solution_value !== want.value) begin
               $error("solution_value expected %h got %h", want.value, rsp_solution_value);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_sweeps_done !== want.sweeps) begin
               $error("sweeps_done expected %0d got %0d", want.sweeps, rsp_sweeps_done);
               errors++;
            end
            if (rsp_last_point !== want.last) begin
               $error("last_point expected %0d got %0d", want.last, rsp_last_point);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall <= 0;
      end else if (stall >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         stall <= stall + 1;
      end
   end

   initial begin
      add_phase(3, 2, '0, '0, MIX_RAW, 2);
      add_item(CMD_NONE, MIX_RAW);
      add_phase(0, 63, TOL_MAX, 16'd2, MIX_DOMINANT, 0);
      add_phase(32, 1, 40'd1048576, 16'd3, MIX_ZERO_CENTRE, 4);
      add_phase(4, 3, '0, 16'hffff, MIX_DIAGONAL, 8);
      while (items_built < 1250)
         add_phase($urandom_range(1, 6), $urandom_range(1, 3), pick_tolerance(),
                   $urandom_range(0, 4), mix_type'($urandom_range(0, 3)),
                   $urandom_range(10, 40));
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (pending_q.size() == 0);
      do @(posedge clock); while (start || busy || answer_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && answer_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
